FILE: sv/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and codes of the embedding index bounds checker.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 31;

  localparam logic [CfgIdxBits-1:0] CFG_CHECK_MODE    = 1'd0;
  localparam logic [CfgIdxBits-1:0] CFG_TOTAL_INDICES = 1'd1;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_BAG   = 2'd1,
    REQ_INDEX = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_FATAL  = 2'd0,
    MODE_WARN   = 2'd1,
    MODE_IGNORE = 2'd2
  } check_mode_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] offset_value;
    logic [30:0]        table_rows;
    logic               is_last_bag;
    logic signed [31:0] index_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] start_out;
    logic signed [31:0] end_out;
    logic signed [31:0] index_out;
    logic               fault;
    logic [31:0]        warning_total;
  } rsp_t;

endpackage

FILE: sv/embedding_index_bounds_checker.sv
// ----------------------------------------------------------------------------
// embedding_index_bounds_checker: request stream offset and index checker
// accepted word: stage register, single compare/clamp stage, result register;
// one word per cycle sustained while out_ready_i holds
// reset clears bag start, row count, warning counter and total; mode is warning
// ----------------------------------------------------------------------------
module embedding_index_bounds_checker
  import ebc_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_rsp_o
);

  localparam int unsigned ValBits   = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int unsigned ExtShift  = 32 - ValBits;

  // values are two's complement in their low ValBits bits
  function automatic logic signed [31:0] val_ext(input logic [31:0] v);
    logic [31:0] shl;
    shl = v << ExtShift;
    return $signed(shl) >>> ExtShift;
  endfunction

  logic [1:0]         mode_q;
  logic [30:0]        total_q;
  logic               s1_valid_q;
  req_t               req_q;
  logic               out_valid_q;
  rsp_t               rsp_q, rsp_d;
  logic signed [31:0] bag_start_q, bag_start_d;
  logic [30:0]        bag_rows_q, bag_rows_d;
  logic [31:0]        warn_cnt_q, warn_cnt_d;

  logic               adv;
  logic               fatal, warn, fix_all;
  logic signed [31:0] off_v, idx_v, total_s;
  logic signed [31:0] s_raw, e_raw, s_min, s_clamp, e_min, e_clamp;
  logic               mism, bad, fix, idx_bad, cnt_clr;
  logic [1:0]         cnt_inc;
  logic [32:0]        cnt_sum;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign fatal   = (mode_q == MODE_FATAL);
  assign warn    = (mode_q == MODE_WARN);
  assign fix_all = !fatal && !warn;

  assign off_v   = val_ext(req_q.offset_value);
  assign idx_v   = val_ext(req_q.index_value);
  assign total_s = $signed({1'b0, total_q});

  // bag offset check and clamp
  always_comb begin
    s_raw = bag_start_q;
    mism  = req_q.is_last_bag && (off_v != total_s);
    e_raw = (mism && !fatal) ? total_s : off_v;
    bad   = (s_raw < 0) || (s_raw > e_raw) || (e_raw > total_s);
    fix   = fix_all || (warn && bad);
    s_min   = (s_raw < total_s) ? s_raw : total_s;
    s_clamp = (s_min > 0) ? s_min : 32'sd0;
    e_min   = (e_raw < total_s) ? e_raw : total_s;
    e_clamp = (e_min > s_clamp) ? e_min : s_clamp;
  end

  // pruned index passes; others must fall in 0 to rows-1
  assign idx_bad = (idx_v != -32'sd1) &&
                   ((idx_v < 0) || ($unsigned(idx_v) >= {1'b0, bag_rows_q}));

  always_comb begin
    rsp_d       = '0;
    bag_start_d = bag_start_q;
    bag_rows_d  = bag_rows_q;
    cnt_inc     = 2'd0;
    cnt_clr     = 1'b0;
    case (req_q.req_type)
      REQ_BEGIN: begin
        cnt_clr         = warn;
        bag_start_d     = off_v;
        rsp_d.start_out = off_v;
      end
      REQ_BAG: begin
        rsp_d.fault     = mism || bad;
        rsp_d.start_out = fix ? s_clamp : s_raw;
        rsp_d.end_out   = fix ? e_clamp : e_raw;
        bag_start_d     = fix ? e_clamp : e_raw;
        bag_rows_d      = req_q.table_rows;
        if (warn) begin
          cnt_inc = {1'b0, mism} + {1'b0, bad};
        end
      end
      REQ_INDEX: begin
        rsp_d.fault     = idx_bad;
        rsp_d.index_out = (idx_bad && !fatal) ? 32'sd0 : idx_v;
        if (warn && idx_bad) begin
          cnt_inc = 2'd1;
        end
      end
      default: begin
      end
    endcase
    cnt_sum = {1'b0, warn_cnt_q} + {31'd0, cnt_inc};
    if (cnt_clr) begin
      warn_cnt_d = '0;
    end else if (cnt_sum[32]) begin
      warn_cnt_d = '1;
    end else begin
      warn_cnt_d = cnt_sum[31:0];
    end
    rsp_d.warning_total = warn_cnt_d;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WARN;
      total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHECK_MODE:    mode_q  <= cfg_data_i[1:0];
        CFG_TOTAL_INDICES: total_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bag_start_q <= '0;
      bag_rows_q  <= '0;
      warn_cnt_q  <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q <= adv || (out_valid_q && !out_ready_i);
      if (adv) begin
        bag_start_q <= bag_start_d;
        bag_rows_q  <= bag_rows_d;
        warn_cnt_q  <= warn_cnt_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_warn_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warn_cnt_q != $past(warn_cnt_q)) |-> ($past(mode_q) == MODE_WARN))
    else $error("warning counter moved outside warning mode");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result word without a held input word");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_cnt_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warn_cnt_q == 32'hFFFF_FFFF) |=> (warn_cnt_q == 32'hFFFF_FFFF || warn_cnt_q == 32'd0))
    else $error("warning counter wrapped");
`endif

endmodule
